[rtl/core/cfft32_pkg.sv]
package cfft32_pkg;

  localparam int unsigned NPts = 32;
  localparam int unsigned IdxW = 5;
  localparam int unsigned WordW = 32;

  localparam logic [WordW-1:0] HalfSqrt2 = 32'h5a82799a;

  typedef logic [WordW-1:0] word_t;

  // Twiddle table, cosine then sine for each rotation.
  function automatic word_t twiddle(input logic [5:0] idx);
    word_t w;
    case (idx)
      6'd0: w = 32'd1073741824;   6'd1: w = 32'd0;
      6'd2: w = 32'd1073741824;   6'd3: w = 32'd0;
      6'd4: w = 32'd1073741824;   6'd5: w = 32'd0;
      6'd6: w = 32'd1402911301;   6'd7: w = -32'sd410903207;
      6'd8: w = 32'd1262586814;   6'd9: w = -32'sd209476638;
      6'd10: w = 32'd1489322693;  6'd11: w = -32'sd596538995;
      6'd12: w = 32'd1518500250;  6'd13: w = -32'sd759250125;
      6'd14: w = 32'd1402911301;  6'd15: w = -32'sd410903207;
      6'd16: w = 32'd1402911301;  6'd17: w = -32'sd992008094;
      6'd18: w = 32'd1402911301;  6'd19: w = -32'sd992008094;
      6'd20: w = 32'd1489322693;  6'd21: w = -32'sd596538995;
      6'd22: w = 32'd843633538;   6'd23: w = -32'sd1053110176;
      6'd24: w = 32'd1073741824;  6'd25: w = -32'sd1073741824;
      6'd26: w = 32'd1518500250;  6'd27: w = -32'sd759250125;
      6'd28: w = 32'd0;           6'd29: w = -32'sd759250125;
      6'd30: w = 32'd581104888;   6'd31: w = -32'sd992008094;
      6'd32: w = 32'd1489322693;  6'd33: w = -32'sd892783698;
      6'd34: w = -32'sd843633538; 6'd35: w = -32'sd209476638;
      6'd36: w = 32'd0;           6'd37: w = -32'sd759250125;
      6'd38: w = 32'd1402911301;  6'd39: w = -32'sd992008094;
      6'd40: w = -32'sd1402911301; 6'd41: w = 32'd410903207;
      6'd42: w = -32'sd581104888; 6'd43: w = -32'sd410903207;
      6'd44: w = 32'd1262586814;  6'd45: w = -32'sd1053110176;
      6'd46: w = -32'sd1489322693; 6'd47: w = 32'd892783698;
      default: w = '0;
    endcase
    return w;
  endfunction

  // Bit reversal of a sample index.
  function automatic logic [IdxW-1:0] bitrev(input logic [IdxW-1:0] k);
    logic [IdxW-1:0] r;
    for (int i = 0; i < IdxW; i++) r[i] = k[IdxW-1-i];
    return r;
  endfunction

  // Upper word of a signed 32 by 32 product.
  function automatic word_t mulhi(input word_t a, input word_t b);
    logic signed [2*WordW-1:0] p;
    p = $signed(a) * $signed(b);
    return p[2*WordW-1:WordW];
  endfunction

  function automatic word_t asr(input word_t x, input logic [1:0] n);
    return word_t'($signed(x) >>> n);
  endfunction

endpackage

[rtl/core/cfft32_front.sv]
// Front end: takes samples, counts the frame and holds each request for the back end.
module cfft32_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             full_i,
  input  cfft32_pkg::word_t                sample_re_i,
  input  cfft32_pkg::word_t                sample_im_i,
  output logic                             push_o,
  output logic [cfft32_pkg::IdxW-1:0]      addr_o,
  output cfft32_pkg::word_t                re_o,
  output cfft32_pkg::word_t                im_o,
  output logic                             busy_o
);

  logic [cfft32_pkg::IdxW-1:0] cnt_q, cnt_d;
  logic [cfft32_pkg::IdxW-1:0] addr_q, addr_d;
  cfft32_pkg::word_t           re_q, re_d, im_q, im_d;
  logic                        vld_q, vld_d;
  logic                        acc, pop;

  // One request register: free when empty or when the back end takes it.
  assign busy_o = vld_q && full_i;
  assign acc    = start_i && !busy_o;
  assign pop    = vld_q && !full_i;
  assign push_o = pop;
  assign addr_o = addr_q;
  assign re_o   = re_q;
  assign im_o   = im_q;
  assign cnt_d  = acc ? cnt_q + 1'b1 : cnt_q;
  assign vld_d  = acc || (vld_q && !pop);
  // Write straight into bit-reversed position, which replaces the swap pass.
  assign addr_d = acc ? cfft32_pkg::bitrev(cnt_q) : addr_q;
  assign re_d   = acc ? sample_re_i : re_q;
  assign im_d   = acc ? sample_im_i : im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      vld_q  <= 1'b0;
      addr_q <= '0;
      re_q   <= '0;
      im_q   <= '0;
    end else begin
      cnt_q  <= cnt_d;
      vld_q  <= vld_d;
      addr_q <= addr_d;
      re_q   <= re_d;
      im_q   <= im_d;
    end
  end

endmodule

[rtl/core/cfft32_back.sv]
// Back end: stores the frame, runs the butterflies and streams the bins.
module cfft32_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [cfft32_pkg::IdxW-1:0] addr_i,
  input  cfft32_pkg::word_t           re_i,
  input  cfft32_pkg::word_t           im_i,
  output logic                        full_o,
  output logic                        valid_o,
  output cfft32_pkg::word_t           bin_re_o,
  output cfft32_pkg::word_t           bin_im_o,
  output logic                        last_bin_o
);

  typedef enum logic [1:0] {StLoad, StR8, StR4, StEmit} state_e;

  state_e            state_q;
  logic [4:0]        cnt_q;
  logic [2:0]        step_q;
  cfft32_pkg::word_t mre_q [32];
  cfft32_pkg::word_t mim_q [32];
  cfft32_pkg::word_t xr_q [8];
  cfft32_pkg::word_t xi_q [8];
  cfft32_pkg::word_t yr_d [8];
  cfft32_pkg::word_t yi_d [8];
  cfft32_pkg::word_t rr_q [4];
  cfft32_pkg::word_t ri_q [4];
  logic [4:0]        a_r8 [8];
  logic [4:0]        a_r4 [4];
  cfft32_pkg::word_t x0r, x0i, x1r, x1i, x2r, x2i;
  cfft32_pkg::word_t bxr, bxi, dxr, dxi, axr, axi, cxr, cxi;

  assign full_o = (state_q != StLoad);

  // Addresses of the current butterfly: eight points or four legs.
  always_comb begin
    for (int i = 0; i < 8; i++) a_r8[i] = {cnt_q[1:0], 3'(i)};
    for (int i = 0; i < 4; i++) a_r4[i] = {2'(i), cnt_q[2:0]};
  end

  // Radix-8 butterfly on the gathered points.
  always_comb begin
    cfft32_pkg::word_t ar, ai, br, bi, cr, ci, dr, di;
    cfft32_pkg::word_t sr, si, tr, ti, ur, ui, vr, vi, wr, wi, yr, yi;
    ar = xr_q[0] + xr_q[1]; ai = xi_q[0] + xi_q[1];
    br = xr_q[0] - xr_q[1]; bi = xi_q[0] - xi_q[1];
    cr = xr_q[2] + xr_q[3]; ci = xi_q[2] + xi_q[3];
    dr = xr_q[2] - xr_q[3]; di = xi_q[2] - xi_q[3];
    sr = cfft32_pkg::asr(ar + cr, 2'd1); ur = cfft32_pkg::asr(ar - cr, 2'd1);
    si = cfft32_pkg::asr(ai + ci, 2'd1); ui = cfft32_pkg::asr(ai - ci, 2'd1);
    tr = cfft32_pkg::asr(br - di, 2'd1); vr = cfft32_pkg::asr(br + di, 2'd1);
    ti = cfft32_pkg::asr(bi + dr, 2'd1); vi = cfft32_pkg::asr(bi - dr, 2'd1);
    ar = xr_q[4] + xr_q[5]; ai = xi_q[4] + xi_q[5];
    br = xr_q[4] - xr_q[5]; bi = xi_q[4] - xi_q[5];
    cr = xr_q[6] + xr_q[7]; ci = xi_q[6] + xi_q[7];
    dr = xr_q[6] - xr_q[7]; di = xi_q[6] - xi_q[7];
    wr = cfft32_pkg::asr(ar + cr, 2'd1); yr = cfft32_pkg::asr(ar - cr, 2'd1);
    wi = cfft32_pkg::asr(ai + ci, 2'd1); yi = cfft32_pkg::asr(ai - ci, 2'd1);
    yr_d[0] = sr + wr; yi_d[0] = si + wi;
    yr_d[4] = sr - wr; yi_d[4] = si - wi;
    yr_d[2] = ur + yi; yi_d[2] = ui - yr;
    yr_d[6] = ur - yi; yi_d[6] = ui + yr;
    // Odd outputs take the rotated terms held from the multiply step.
    yr_d[3] = tr - rr_q[0]; yi_d[3] = ti - ri_q[0];
    yr_d[7] = tr + rr_q[0]; yi_d[7] = ti + ri_q[0];
    yr_d[1] = vr + ri_q[1]; yi_d[1] = vi - rr_q[1];
    yr_d[5] = vr - ri_q[1]; yi_d[5] = vi + rr_q[1];
    bxr = br - di; bxi = bi + dr; dxr = br + di; dxi = bi - dr;
  end

  // Radix-4 butterfly on rotated legs held in rr_q/ri_q.
  always_comb begin
    cfft32_pkg::word_t s2, s3, d2, d3;
    axr = cfft32_pkg::asr(xr_q[0], 2'd2); axi = cfft32_pkg::asr(xi_q[0], 2'd2);
    s2 = rr_q[2] + rr_q[3]; d2 = rr_q[2] - rr_q[3];
    s3 = ri_q[3] - ri_q[2]; d3 = ri_q[3] + ri_q[2];
    cxr = axr - rr_q[1]; cxi = axi - ri_q[1];
    x0r = rr_q[1] + axr; x0i = ri_q[1] + axi;
    x1r = s2; x1i = d3; x2r = s3; x2i = d2;
  end

  // Rotation of one leg through the shared multipliers.
  function automatic void rot(input cfft32_pkg::word_t pr, input cfft32_pkg::word_t pi,
                              input logic [5:0] t, output cfft32_pkg::word_t re,
                              output cfft32_pkg::word_t im);
    cfft32_pkg::word_t c, s, cm;
    c  = cfft32_pkg::twiddle(t);
    s  = cfft32_pkg::twiddle(t + 6'd1);
    cm = cfft32_pkg::mulhi(s, pr + pi);
    im = cfft32_pkg::mulhi(c, pi) + cm;
    re = cfft32_pkg::mulhi(c + {s[30:0], 1'b0}, pr) - cm;
  endfunction

  // Sequencer: load, four radix-8 passes of three steps, eight radix-4 passes of
  // five steps (gather, rotate legs 1 to 3 one per step, write back), then emit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    cfft32_pkg::word_t tre, tim;
    logic [5:0] tb;
    if (!rst_ni) begin
      state_q    <= StLoad;
      cnt_q      <= '0;
      step_q     <= '0;
      valid_o    <= 1'b0;
      last_bin_o <= 1'b0;
    end else begin
      valid_o    <= (state_q == StEmit);
      last_bin_o <= (state_q == StEmit) && (cnt_q == 5'd31);
      unique case (state_q)
        StLoad: begin
          if (push_i) begin
            mre_q[addr_i] <= re_i;
            mim_q[addr_i] <= im_i;
            if (addr_i == 5'd31) begin
              state_q <= StR8;
              cnt_q   <= '0;
              step_q  <= '0;
            end
          end
        end
        StR8: begin
          case (step_q)
            3'd0: begin
              for (int i = 0; i < 8; i++) begin
                xr_q[i] <= mre_q[a_r8[i]];
                xi_q[i] <= mim_q[a_r8[i]];
              end
              step_q <= 3'd1;
            end
            3'd1: begin
              rr_q[0] <= cfft32_pkg::mulhi(cfft32_pkg::HalfSqrt2, bxr - bxi);
              ri_q[0] <= cfft32_pkg::mulhi(cfft32_pkg::HalfSqrt2, bxr + bxi);
              rr_q[1] <= cfft32_pkg::mulhi(cfft32_pkg::HalfSqrt2, dxr - dxi);
              ri_q[1] <= cfft32_pkg::mulhi(cfft32_pkg::HalfSqrt2, dxr + dxi);
              step_q  <= 3'd2;
            end
            default: begin
              for (int i = 0; i < 8; i++) begin
                mre_q[a_r8[i]] <= yr_d[i];
                mim_q[a_r8[i]] <= yi_d[i];
              end
              step_q <= '0;
              if (cnt_q[1:0] == 2'd3) begin
                state_q <= StR4;
                cnt_q   <= '0;
              end else begin
                cnt_q   <= cnt_q + 5'd1;
              end
            end
          endcase
        end
        StR4: begin
          tb = 6'(cnt_q[2:0] * 6);
          case (step_q) inside
            3'd0: begin
              for (int i = 0; i < 4; i++) begin
                xr_q[i] <= mre_q[a_r4[i]];
                xi_q[i] <= mim_q[a_r4[i]];
              end
              step_q <= 3'd1;
            end
            [3'd1:3'd3]: begin
              rot(xr_q[step_q[1:0]], xi_q[step_q[1:0]],
                  tb + 6'({step_q[1:0] - 2'd1, 1'b0}), tre, tim);
              rr_q[step_q[1:0]] <= tre;
              ri_q[step_q[1:0]] <= tim;
              step_q <= step_q + 3'd1;
            end
            default: begin
              mre_q[a_r4[0]] <= x0r + x1r; mim_q[a_r4[0]] <= x0i + x1i;
              mre_q[a_r4[1]] <= cxr - x2r; mim_q[a_r4[1]] <= cxi - x2i;
              mre_q[a_r4[2]] <= x0r - x1r; mim_q[a_r4[2]] <= x0i - x1i;
              mre_q[a_r4[3]] <= cxr + x2r; mim_q[a_r4[3]] <= cxi + x2i;
              step_q <= '0;
              if (cnt_q[2:0] == 3'd7) begin
                state_q <= StEmit;
                cnt_q   <= '0;
              end else begin
                cnt_q   <= cnt_q + 5'd1;
              end
            end
          endcase
        end
        default: begin
          bin_re_o   <= mre_q[cnt_q];
          bin_im_o   <= mim_q[cnt_q];
          cnt_q      <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) state_q <= StLoad;
        end
      endcase
    end
  end

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_bin_o |-> valid_o) else $error("last without valid");
  a_no_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> !push_i) else $error("push while busy");
  a_load_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_bin_o |-> state_q == StLoad) else $error("frame not closed");

endmodule

[rtl/core/complex_fft_32_point.sv]
// 32-point complex FFT. Give 32 samples with start_i while busy_o is low, at most
// one a cycle; each sample is held in the front register until the back end
// stores it. After the last sample the block computes four radix-8 butterflies
// with four constant multiplies, then eight radix-4 butterflies that rotate one
// leg a cycle through three shared multipliers, and emits 32 bins on consecutive
// cycles with bin_valid_o, last_bin_o on the final one. The receiver cannot
// stall the output. One sample of the next frame can be taken while the block
// computes; busy_o then stays high until emitting ends.
module complex_fft_32_point (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [31:0]       sample_re_i,
  input  logic [31:0]       sample_im_i,
  output logic              bin_valid_o,
  output logic [31:0]       bin_re_o,
  output logic [31:0]       bin_im_o,
  output logic              last_bin_o
);

  logic                        push, full;
  logic [cfft32_pkg::IdxW-1:0] addr;
  cfft32_pkg::word_t           wre, wim;

  cfft32_front u_front (
    .clk_i, .rst_ni, .start_i, .full_i(full), .sample_re_i, .sample_im_i,
    .push_o(push), .addr_o(addr), .re_o(wre), .im_o(wim), .busy_o
  );

  cfft32_back u_back (
    .clk_i, .rst_ni, .push_i(push), .addr_i(addr), .re_i(wre), .im_i(wim),
    .full_o(full), .valid_o(bin_valid_o), .bin_re_o, .bin_im_o, .last_bin_o
  );

endmodule
